>>> rtl/core/rtcc_pkg.sv
// Shared types and codes for the RGB threshold color classifier.
// No dependencies; every other file in rtl/core imports this package.
package rtcc_pkg;

  // Operating modes held in the mode register.
  localparam logic [2:0] MODE_RED    = 3'd0;
  localparam logic [2:0] MODE_GREEN  = 3'd1;
  localparam logic [2:0] MODE_BLUE   = 3'd2;
  localparam logic [2:0] MODE_YELLOW = 3'd3;
  localparam logic [2:0] MODE_BLACK  = 3'd4;
  localparam logic [2:0] MODE_ALL    = 3'd5;

  // Pixel class codes; the verdict uses the same codes for the four colors.
  localparam logic [2:0] CLS_NONE   = 3'd0;
  localparam logic [2:0] CLS_RED    = 3'd1;
  localparam logic [2:0] CLS_GREEN  = 3'd2;
  localparam logic [2:0] CLS_BLUE   = 3'd3;
  localparam logic [2:0] CLS_YELLOW = 3'd4;
  localparam logic [2:0] CLS_BLACK  = 3'd5;

  // Configuration register indexes.
  localparam logic [2:0] REG_MODE       = 3'd0;
  localparam logic [2:0] REG_RED_LIM    = 3'd1;
  localparam logic [2:0] REG_GREEN_LIM  = 3'd2;
  localparam logic [2:0] REG_BLUE_LIM   = 3'd3;
  localparam logic [2:0] REG_YELLOW_LIM = 3'd4;
  localparam logic [2:0] REG_BLACK_LIM  = 3'd5;
  localparam logic [2:0] REG_YELLOW_TOL = 3'd6;

  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned NUM_COLORS = 4;

  // Limit registers: minimum of the primary channel(s) in the high byte,
  // maximum of the secondary channel(s) in the low byte.
  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] red_lim;
    logic [15:0] green_lim;
    logic [15:0] blue_lim;
    logic [15:0] yellow_lim;
    logic [7:0]  black_lim;
    logic [7:0]  yellow_tol;
  } rtcc_cfg_t;

  // Classification of one pixel and whether it takes part in the tally.
  typedef struct packed {
    logic [2:0] cls;
    logic       tally;
  } rtcc_hit_t;

endpackage

>>> rtl/core/rtcc_regs.sv
// Configuration register file of the color classifier.
// Depends on rtcc_pkg for the register indexes and the configuration struct.
module rtcc_regs
  import rtcc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output rtcc_cfg_t             cfg
);

  rtcc_cfg_t cfg_r;
  rtcc_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        REG_MODE:       cfg_nxt.mode       = cfg_wdata[2:0];
        REG_RED_LIM:    cfg_nxt.red_lim    = cfg_wdata;
        REG_GREEN_LIM:  cfg_nxt.green_lim  = cfg_wdata;
        REG_BLUE_LIM:   cfg_nxt.blue_lim   = cfg_wdata;
        REG_YELLOW_LIM: cfg_nxt.yellow_lim = cfg_wdata;
        REG_BLACK_LIM:  cfg_nxt.black_lim  = cfg_wdata[7:0];
        REG_YELLOW_TOL: cfg_nxt.yellow_tol = cfg_wdata[7:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode       <= MODE_ALL;
      cfg_r.red_lim    <= 16'h8040;
      cfg_r.green_lim  <= 16'h409B;
      cfg_r.blue_lim   <= 16'h4081;
      cfg_r.yellow_lim <= 16'h9681;
      cfg_r.black_lim  <= 8'd64;
      cfg_r.yellow_tol <= 8'd50;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/core/rtcc_match.sv
// Threshold tests of one pixel against the class limits, and the mode select.
// Depends on rtcc_pkg for the configuration struct and the class codes.
module rtcc_match
  import rtcc_pkg::*;
(
  input  rtcc_cfg_t  cfg,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  output rtcc_hit_t  hit
);

  logic       is_red, is_green, is_blue, is_yellow, is_black;
  logic [7:0] rg_diff;

  assign rg_diff = (red >= green) ? (red - green) : (green - red);

  assign is_red = (red >= cfg.red_lim[15:8]) && (green <= cfg.red_lim[7:0]) &&
                  (blue <= cfg.red_lim[7:0]);

  assign is_green = (green >= cfg.green_lim[15:8]) && (green > red) && (green > blue) &&
                    (red <= cfg.green_lim[7:0]) && (blue <= cfg.green_lim[7:0]);

  assign is_blue = (blue >= cfg.blue_lim[15:8]) && (red <= cfg.blue_lim[7:0]) &&
                   (blue > red) && (blue >= green);

  assign is_yellow = (red >= cfg.yellow_lim[15:8]) && (green >= cfg.yellow_lim[15:8]) &&
                     (blue <= cfg.yellow_lim[7:0]) && (rg_diff <= cfg.yellow_tol);

  assign is_black = (red <= cfg.black_lim) && (green <= cfg.black_lim) &&
                    (blue <= cfg.black_lim);

  always_comb begin
    hit.cls   = CLS_NONE;
    hit.tally = 1'b0;
    case (cfg.mode)
      MODE_RED:    if (is_red)    hit.cls = CLS_RED;
      MODE_GREEN:  if (is_green)  hit.cls = CLS_GREEN;
      MODE_BLUE:   if (is_blue)   hit.cls = CLS_BLUE;
      MODE_YELLOW: if (is_yellow) hit.cls = CLS_YELLOW;
      MODE_BLACK:  if (is_black)  hit.cls = CLS_BLACK;
      MODE_ALL: begin
        hit.tally = 1'b1;
        if (is_red)         hit.cls = CLS_RED;
        else if (is_green)  hit.cls = CLS_GREEN;
        else if (is_blue)   hit.cls = CLS_BLUE;
        else if (is_yellow) hit.cls = CLS_YELLOW;
      end
      default: hit.cls = CLS_NONE;
    endcase
  end

endmodule

>>> rtl/core/rtcc_tally.sv
// Saturating hit counters of the four colors and the majority verdict.
// Depends on rtcc_pkg for the class codes and the hit struct.
module rtcc_tally
  import rtcc_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  rtcc_hit_t  hit,
  input  logic       last,
  output logic       verdict_valid,
  output logic [2:0] verdict
);

  logic [COUNT_WIDTH-1:0] cnt_r   [NUM_COLORS];
  logic [COUNT_WIDTH-1:0] cnt_nxt [NUM_COLORS];
  logic [COUNT_WIDTH-1:0] cnt_inc [NUM_COLORS];
  logic [NUM_COLORS-1:0]  win;

  // Counts including the current pixel; a full counter stays full.
  always_comb begin
    for (int i = 0; i < NUM_COLORS; i++) begin
      if ((hit.cls == 3'(i + 1)) && (cnt_r[i] != '1)) begin
        cnt_inc[i] = cnt_r[i] + 1'b1;
      end else begin
        cnt_inc[i] = cnt_r[i];
      end
    end
  end

  // A color wins only when its count is strictly above all three others.
  always_comb begin
    for (int i = 0; i < NUM_COLORS; i++) begin
      win[i] = 1'b1;
      for (int j = 0; j < NUM_COLORS; j++) begin
        if ((i != j) && !(cnt_inc[i] > cnt_inc[j])) begin
          win[i] = 1'b0;
        end
      end
    end
  end

  assign verdict_valid = hit.tally && last;

  always_comb begin
    verdict = CLS_NONE;
    if (verdict_valid) begin
      if (win[0])      verdict = CLS_RED;
      else if (win[1]) verdict = CLS_GREEN;
      else if (win[2]) verdict = CLS_BLUE;
      else if (win[3]) verdict = CLS_YELLOW;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_COLORS; i++) begin
      cnt_nxt[i] = cnt_r[i];
      if (step && hit.tally) begin
        cnt_nxt[i] = last ? '0 : cnt_inc[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_COLORS; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_COLORS; i++) begin
        cnt_r[i] <= cnt_nxt[i];
      end
    end
  end

endmodule

>>> rtl/core/rgb_threshold_color_classifier.sv
// RGB threshold color classifier, top level.
// A pixel accepted sits in the input register; its result moves into the result register,
// with out_tvalid high, when that register is free.
// Throughput: one pixel per cycle; the input stalls only while a held result blocks both.
// Reset (rst_n low, synchronous): both registers empty, hit counters zero, registers at
// defaults.
module rgb_threshold_color_classifier
  import rtcc_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // red_in [7:0], green_in [15:8], blue_in [23:16]
  input  logic [23:0]           in_tdata,
  input  logic                  in_tlast,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // red_out [7:0], green_out [15:8], blue_out [23:16], pixel_class [26:24],
  // verdict_valid [27], verdict [30:28], zero [31]
  output logic [31:0]           out_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  rtcc_cfg_t  cfg;

  logic        s1_valid_r;
  logic [23:0] s1_pix_r;
  logic        s1_last_r;

  rtcc_hit_t   s1_hit;

  logic        out_valid_r;
  logic [31:0] out_data_r;
  logic [31:0] out_data_nxt;

  logic        out_free, s1_free, step;
  logic        verdict_valid;
  logic [2:0]  verdict;
  logic [23:0] color;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_free   = !s1_valid_r || out_free;
  assign step      = s1_valid_r && out_free;
  assign in_tready = s1_free;

  rtcc_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rtcc_match u_match (
    .cfg   (cfg),
    .red   (s1_pix_r[7:0]),
    .green (s1_pix_r[15:8]),
    .blue  (s1_pix_r[23:16]),
    .hit   (s1_hit)
  );

  rtcc_tally #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_tally (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .hit           (s1_hit),
    .last          (s1_last_r),
    .verdict_valid (verdict_valid),
    .verdict       (verdict)
  );

  // Pure color of the class, packed blue, green, red from the top.
  always_comb begin
    case (s1_hit.cls)
      CLS_RED:    color = 24'h0000FF;
      CLS_GREEN:  color = 24'h00FF00;
      CLS_BLUE:   color = 24'hFF0000;
      CLS_YELLOW: color = 24'h00FFFF;
      CLS_BLACK:  color = 24'h000000;
      default:    color = 24'hFFFFFF;
    endcase
  end

  assign out_data_nxt = {1'b0, verdict, verdict_valid, s1_hit.cls, color};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_free) s1_valid_r <= in_tvalid;
      if (out_free) out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && in_tvalid) begin
      s1_pix_r  <= in_tdata;
      s1_last_r <= in_tlast;
    end
    if (step) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
